>>> hdl/cht_pkg.sv
package cht_pkg;

    localparam int TABLE_BITS   = 13;
    localparam int SECOND_SHIFT = 16;
    localparam int MAX_KICKS    = 64;

    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int KEY_W      = 64;
    localparam int PAY_W      = 16;
    localparam int ENTRY_W    = KEY_W + PAY_W;
    localparam int KICK_W     = $clog2(MAX_KICKS + 1);
    localparam int OUT_W      = 24;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LK_RD1,
        ST_LK_CHK1,
        ST_LK_CHK2,
        ST_INS_WR,
        ST_INS_CHK,
        ST_DONE
    } t_state;

    function automatic logic [TABLE_BITS-1:0] slot_one(input logic [KEY_W-1:0] key);
        return key[TABLE_BITS-1:0];
    endfunction

    function automatic logic [TABLE_BITS-1:0] slot_two(input logic [KEY_W-1:0] key);
        return key[SECOND_SHIFT +: TABLE_BITS];
    endfunction

endpackage

>>> hdl/cuckoo_hash_table.sv
// two-choice cuckoo hash table, 64-bit keys with 16-bit payloads (payload 0 = empty)
// input channel s_axis: tuser is the opcode (0 insert, 1 lookup), tdata carries
// search_key in [63:0] and payload in [79:64]
// output channel m_axis: one transaction per input transaction, tdata carries
// hit in [0], found_payload in [16:1], insert_failed in [17], zeros above
// all table traffic goes through one single-port memory with a registered read;
// a small sequencer reuses that port and one key compare for every step
// lookup: slot one is read and checked first, and slot two is read and checked only
// on a miss there (one read per candidate slot); the result then goes to the output
// register, and the next transaction can be accepted once the sequencer is idle again
// insert: each displacement writes the pair while reading the old occupant, then
// examines it; an insert makes at most MAX_KICKS writes, and an insert with payload
// 0 writes nothing and goes straight to the result
// one item is worked on at a time; s_axis_tready is high only while idle
// after reset the table is cleared one entry per cycle, all 8192 entries, during which
// no input transaction is accepted
// the output register holds a result until taken; the next item may be accepted
// and processed meanwhile, and its result waits in the sequencer until the register frees
module cuckoo_hash_table
    import cht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [79:0]      s_axis_tdata,   // search_key[63:0], payload[79:64]
    input  logic             s_axis_tuser,   // opcode[0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // hit[0], found_payload[16:1], insert_failed[17]
);

    t_state r_state, n_state;

    logic [TABLE_BITS-1:0] r_pos;
    logic [KICK_W-1:0]     r_kicks;
    logic                  r_op;
    logic [KEY_W-1:0]      r_key;
    logic [PAY_W-1:0]      r_pay;
    logic                  r_res_hit;
    logic [PAY_W-1:0]      r_res_fp;
    logic                  r_res_fail;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic [ENTRY_W-1:0]    mem [TABLE_SIZE];
    logic [ENTRY_W-1:0]    r_rdata;
    logic                  mem_we;
    logic [TABLE_BITS-1:0] mem_addr;
    logic [ENTRY_W-1:0]    mem_wdata;

    logic [KEY_W-1:0]      rd_key;
    logic [PAY_W-1:0]      rd_pay;
    logic                  rd_match;
    logic [TABLE_BITS-1:0] victim_pos;
    logic                  in_xfer;
    logic                  out_load;
    logic [KEY_W-1:0]      in_key;
    logic [PAY_W-1:0]      in_pay;

    assign in_key = s_axis_tdata[KEY_W-1:0];
    assign in_pay = s_axis_tdata[KEY_W +: PAY_W];

    assign rd_key   = r_rdata[ENTRY_W-1:PAY_W];
    assign rd_pay   = r_rdata[PAY_W-1:0];
    assign rd_match = (rd_pay != '0) && (rd_key == r_key);
    // victim moves to its other slot
    assign victim_pos = (r_pos == slot_one(rd_key)) ? slot_two(rd_key) : slot_one(rd_key);

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_pos == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_axis_tuser == OP_LOOKUP) n_state = ST_LK_RD1;
                    else if (in_pay != '0) n_state = ST_INS_WR;
                    else n_state = ST_DONE;
                end
            end
            ST_LK_RD1:  n_state = ST_LK_CHK1;
            ST_LK_CHK1: n_state = rd_match ? ST_DONE : ST_LK_CHK2;
            ST_LK_CHK2: n_state = ST_DONE;
            ST_INS_WR:  n_state = ST_INS_CHK;
            ST_INS_CHK: begin
                if (rd_pay == '0 || r_kicks == KICK_W'(MAX_KICKS)) n_state = ST_DONE;
                else n_state = ST_INS_WR;
            end
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // memory port and handshake controls
    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = r_pos;
        mem_wdata     = {r_key, r_pay};
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            ST_IDLE:    s_axis_tready = 1'b1;
            ST_LK_CHK1: mem_addr = slot_two(r_key);
            ST_INS_WR:  mem_we = 1'b1;   // read-first port returns the old occupant
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_rdata <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_CLEAR: r_pos <= r_pos + 1'b1;
                ST_IDLE: begin
                    if (in_xfer) r_pos <= slot_one(in_key);
                end
                ST_INS_CHK: r_pos <= victim_pos;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    r_op       <= s_axis_tuser;
                    r_key      <= in_key;
                    r_pay      <= in_pay;
                    r_kicks    <= '0;
                    r_res_hit  <= 1'b0;
                    r_res_fp   <= '0;
                    r_res_fail <= 1'b0;
                end
            end
            ST_LK_CHK1, ST_LK_CHK2: begin
                if (rd_match) begin
                    r_res_hit <= 1'b1;
                    r_res_fp  <= rd_pay;
                end
            end
            ST_INS_WR: r_kicks <= r_kicks + 1'b1;
            ST_INS_CHK: begin
                if (rd_pay != '0) begin
                    if (r_kicks == KICK_W'(MAX_KICKS)) begin
                        r_res_fail <= 1'b1;   // last victim is dropped
                    end else begin
                        r_key <= rd_key;
                        r_pay <= rd_pay;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {{(OUT_W - PAY_W - 2){1'b0}}, r_res_fail, r_res_fp, r_res_hit};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !s_axis_tready)
        else $error("input accepted during table clear");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state != ST_IDLE && r_state != ST_CLEAR)
        else $error("sequencer did not start after acceptance");

    a_kick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS_WR || r_state == ST_INS_CHK) |-> r_kicks <= KICK_W'(MAX_KICKS))
        else $error("displacement count beyond bound");

    a_hit_fail_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !(r_res_hit && r_res_fail))
        else $error("result flags both hit and insert failure");

    a_lookup_no_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_op == OP_LOOKUP |-> !r_res_fail)
        else $error("lookup reported insert failure");

    a_miss_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && !r_res_hit |-> r_res_fp == '0)
        else $error("nonzero payload without hit");
`endif

endmodule
